// File: hdl/esm_pkg.sv
// Shared types, constants and the pitch step table of the eight-voice sample mixer.
package esm_pkg;

  localparam int VOICES              = 8;
  localparam int SAMPLE_MEMORY_DEPTH = 65536;
  localparam int VIDX_W              = $clog2(VOICES);
  localparam int MEM_AW              = $clog2(SAMPLE_MEMORY_DEPTH);
  localparam int QDEPTH              = 2;
  localparam int QPTR_W              = $clog2(QDEPTH);
  localparam int QCNT_W              = $clog2(QDEPTH + 1);

  localparam logic [VIDX_W-1:0] VLAST = VIDX_W'(VOICES - 1);

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_MIX    = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_MIX   = 1'b1;

  localparam logic [15:0] HANDLE_FIRST = 16'd100;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'b001,
    OP_START = 3'b010,
    OP_MIX   = 3'b100
  } op_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  sample_byte;
    logic [16:0] length;
    logic [6:0]  volume;
    logic [7:0]  separation;
    logic [7:0]  pitch;
    logic [7:0]  sound_id;
    logic        exclusive;
    logic [30:0] now;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [15:0]        handle;
  } res_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic valid;
    op_t  op;
    cmd_t cmd;
  } head_t;

  // 2^(m/64) scaled by 2^17, one octave; lower octaves shift right.
  localparam logic [17:0] STEP_BASE [64] = '{
    18'd131072, 18'd132499, 18'd133942, 18'd135400,
    18'd136875, 18'd138365, 18'd139872, 18'd141395,
    18'd142935, 18'd144491, 18'd146064, 18'd147655,
    18'd149263, 18'd150888, 18'd152531, 18'd154192,
    18'd155871, 18'd157569, 18'd159284, 18'd161019,
    18'd162772, 18'd164545, 18'd166337, 18'd168148,
    18'd169979, 18'd171830, 18'd173701, 18'd175592,
    18'd177504, 18'd179437, 18'd181391, 18'd183367,
    18'd185363, 18'd187382, 18'd189422, 18'd191485,
    18'd193570, 18'd195678, 18'd197809, 18'd199963,
    18'd202140, 18'd204341, 18'd206566, 18'd208816,
    18'd211090, 18'd213388, 18'd215712, 18'd218061,
    18'd220435, 18'd222836, 18'd225262, 18'd227715,
    18'd230195, 18'd232702, 18'd235236, 18'd237797,
    18'd240387, 18'd243004, 18'd245650, 18'd248325,
    18'd251029, 18'd253763, 18'd256526, 18'd259320
  };

  // 3.16 step for a pitch index; 128 gives exactly 1.0.
  function automatic logic [18:0] pitch_step_of(input logic [7:0] p);
    logic [17:0] base;
    base = STEP_BASE[p[5:0]];
    return {1'b0, base >> (~p[7:6])};
  endfunction

endpackage

// File: hdl/esm_front.sv
// Front end: accepts command items, classifies them and queues them for the back end.
module esm_front import esm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_stall,
  input  cmd_t  cmd,
  output head_t head,
  input  logic  pop
);

  op_t              q_op  [QDEPTH];
  cmd_t             q_cmd [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] count;
  op_t              op;
  logic             known;
  logic             push;

  // Map the action code; unused codes are taken and dropped.
  always_comb begin
    op    = OP_LOAD;
    known = 1'b1;
    case (cmd.action)
      ACT_LOAD:  op = OP_LOAD;
      ACT_START: op = OP_START;
      ACT_MIX:   op = OP_MIX;
      default:   known = 1'b0;
    endcase
  end

  assign cmd_stall = (count == QCNT_W'(QDEPTH));
  assign push      = cmd_valid && !cmd_stall && known;

  assign head.valid = (count != '0);
  assign head.op    = q_op[rp];
  assign head.cmd   = q_cmd[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wp]  <= op;
      q_cmd[wp] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QPTR_W'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == QPTR_W'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/esm_back.sv
// Back end: sample memory, voice state, start sequencer, mix pipeline and result register.
module esm_back import esm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  head_t head,
  output logic  pop,
  output res_t  res,
  output logic  res_valid,
  input  logic  res_stall
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXCL  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_CLAIM = 7'b0001000,
    S_MIX   = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  // Voice state
  logic [VOICES-1:0] active;
  logic [16:0]       rptr   [VOICES];
  logic [16:0]       end_a  [VOICES];
  logic [18:0]       step   [VOICES];
  logic [15:0]       frac   [VOICES];
  logic [30:0]       tick   [VOICES];
  logic [7:0]        vid    [VOICES];
  logic [6:0]        vol_l  [VOICES];
  logic [6:0]        vol_r  [VOICES];
  logic [15:0]       hcnt;

  logic [7:0] mem [SAMPLE_MEMORY_DEPTH];
  logic [7:0] rdata;
  logic       mem_we;

  cmd_t              cur;
  logic [VIDX_W-1:0] cnt;

  // Start bookkeeping
  logic [VOICES-1:0] clr;
  logic              found;
  logic [8:0]        sep1;
  logic [8:0]        sep_r;
  logic [16:0]       sq_l;
  logic [16:0]       sq_r;
  logic [23:0]       prod_l;
  logic [23:0]       prod_r;
  logic [6:0]        lv_new;
  logic [6:0]        rv_new;
  logic [30:0]       oldest;
  logic [VIDX_W-1:0] oidx;
  logic              free_found;
  logic [VIDX_W-1:0] free_idx;
  logic [VIDX_W-1:0] slot;
  logic [17:0]       esum;
  logic [16:0]       e_addr;
  logic [15:0]       hval;

  // Voice advance
  logic [19:0] fsum;
  logic [17:0] ptr;

  // Mix pipeline
  logic        issue;
  logic        p1_v, p2_v, p3_v;
  logic [6:0]  p1_vl, p1_vr;
  logic        neg;
  logic [7:0]  mag;
  logic [14:0] p2_ml, p2_mr;
  logic        p2_neg;
  logic [15:0] p3_yl, p3_yr;
  logic [25:0] p3_pl, p3_pr;
  logic        p3_neg;
  logic [9:0]  q1_l, q1_r;
  logic [16:0] rem_l, rem_r;
  logic [16:0] mag_l, mag_r;
  logic signed [19:0] val_l, val_r;
  logic signed [19:0] acc_l, acc_r;

  logic out_free;
  logic res_load;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  assign out_free = !res_valid || !res_stall;
  assign pop      = (state == S_IDLE) && head.valid;
  assign mem_we   = pop && (head.op == OP_LOAD);
  assign issue    = (state == S_MIX);
  assign res_load = ((state == S_CLAIM) || (state == S_OUT)) && out_free;
  assign slot     = free_found ? free_idx : oidx;
  assign hval     = (hcnt == '0) ? HANDLE_FIRST : hcnt;

  // When the exclusive flag is set, drop the first active voice that carries the same sound id.
  always_comb begin
    found = 1'b0;
    clr   = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (cur.exclusive && active[i] && (vid[i] == cur.sound_id) && !found) begin
        clr[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  always_comb begin
    sep1   = {1'b0, cur.separation} + 9'd1;
    sep_r  = 9'd257 - sep1;
    prod_l = {17'b0, cur.volume} * {7'b0, sq_l};
    prod_r = {17'b0, cur.volume} * {7'b0, sq_r};
    esum   = {2'b0, cur.address} + {1'b0, cur.length};
    e_addr = esum[17] ? 17'h1ffff : esum[16:0];
    fsum   = {4'b0, frac[cnt]} + {1'b0, step[cnt]};
    ptr    = {1'b0, rptr[cnt]} + {14'b0, fsum[19:16]};
  end

  // Sample to signed offset magnitude.
  always_comb begin
    neg = (rdata < 8'd128);
    mag = neg ? (8'd128 - rdata) : (rdata - 8'd128);
  end

  // y + floor(y/127), with floor(y/127) from an under-estimate and one correction step.
  always_comb begin
    q1_l  = p3_pl[25:16];
    q1_r  = p3_pr[25:16];
    rem_l = {1'b0, p3_yl} - ({q1_l, 7'b0} - {7'b0, q1_l});
    rem_r = {1'b0, p3_yr} - ({q1_r, 7'b0} - {7'b0, q1_r});
    mag_l = {1'b0, p3_yl} + {7'b0, q1_l} + {16'b0, (rem_l >= 17'd127)};
    mag_r = {1'b0, p3_yr} + {7'b0, q1_r} + {16'b0, (rem_r >= 17'd127)};
    val_l = p3_neg ? -$signed({3'b0, mag_l}) : $signed({3'b0, mag_l});
    val_r = p3_neg ? -$signed({3'b0, mag_r}) : $signed({3'b0, mag_r});
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.cmd.address[MEM_AW-1:0]] <= head.cmd.sample_byte;
    end
    rdata <= mem[rptr[cnt][MEM_AW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      hcnt      <= '0;
      res_valid <= 1'b0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
    end else begin
      p1_v <= issue && active[cnt];
      p2_v <= p1_v;
      p3_v <= p2_v;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.op)
              OP_START: state <= S_EXCL;
              OP_MIX:   state <= S_MIX;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_EXCL: begin
          active <= active & ~clr;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (cnt == VLAST) state <= S_CLAIM;
        end
        S_CLAIM: begin
          if (out_free) begin
            active[slot] <= 1'b1;
            hcnt         <= hval + 16'd1;
            state        <= S_IDLE;
          end
        end
        S_MIX: begin
          if (active[cnt] && (ptr >= {1'b0, end_a[cnt]})) active[cnt] <= 1'b0;
          if (cnt == VLAST) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!p1_v && !p2_v && !p3_v) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload and voice data
  always_ff @(posedge clk) begin
    p1_vl  <= vol_l[cnt];
    p1_vr  <= vol_r[cnt];
    p2_ml  <= {8'b0, p1_vl} * {7'b0, mag};
    p2_mr  <= {8'b0, p1_vr} * {7'b0, mag};
    p2_neg <= neg;
    p3_yl  <= {p2_ml, 1'b0};
    p3_yr  <= {p2_mr, 1'b0};
    p3_pl  <= {10'b0, p2_ml, 1'b0} * 26'd516;
    p3_pr  <= {10'b0, p2_mr, 1'b0} * 26'd516;
    p3_neg <= p2_neg;

    if (pop && (head.op == OP_MIX)) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (p3_v) begin
      acc_l <= acc_l + val_l;
      acc_r <= acc_r + val_r;
    end

    case (state)
      S_IDLE: begin
        if (pop) begin
          cur <= head.cmd;
          cnt <= '0;
        end
      end
      S_EXCL: begin
        sq_l       <= {8'b0, sep1} * {8'b0, sep1};
        sq_r       <= {8'b0, sep_r} * {8'b0, sep_r};
        oldest     <= cur.now;
        oidx       <= '0;
        free_found <= 1'b0;
        free_idx   <= '0;
        cnt        <= '0;
      end
      S_SCAN: begin
        if (!active[cnt] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cnt;
        end
        if (active[cnt] && (tick[cnt] < oldest)) begin
          oldest <= tick[cnt];
          oidx   <= cnt;
        end
        lv_new <= cur.volume - prod_l[22:16];
        rv_new <= cur.volume - prod_r[22:16];
        if (cnt != VLAST) cnt <= cnt + 1'b1;
      end
      S_CLAIM: begin
        if (out_free) begin
          rptr[slot]  <= {1'b0, cur.address};
          end_a[slot] <= e_addr;
          step[slot]  <= pitch_step_of(cur.pitch);
          frac[slot]  <= '0;
          tick[slot]  <= cur.now;
          vid[slot]   <= cur.sound_id;
          vol_l[slot] <= lv_new;
          vol_r[slot] <= rv_new;
          res.kind         <= KIND_START;
          res.left_sample  <= '0;
          res.right_sample <= '0;
          res.handle       <= hval;
        end
      end
      S_MIX: begin
        if (active[cnt]) begin
          frac[cnt] <= fsum[15:0];
          rptr[cnt] <= (ptr >= {1'b0, end_a[cnt]}) ? '0 : ptr[16:0];
        end
        if (cnt != VLAST) cnt <= cnt + 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          res.kind         <= KIND_MIX;
          res.left_sample  <= sat16(acc_l);
          res.right_sample <= sat16(acc_r);
          res.handle       <= '0;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

// File: hdl/eight_voice_sample_mixer_core.sv
// Eight-voice sample playback mixer: top level with front end, command queue and back end.
//
// Commands enter on the cmd channel and are queued two deep, so the caller
// can keep sending while the back end works and a finished result waits on
// the res channel. A load item writes one byte into the 64K-entry sample
// memory and returns nothing. A start item drops a matching voice when the
// exclusive flag is set, walks the eight voices to find the first free one
// or the oldest by start tick, and claims the voice and posts the handle
// once the result register is free. A mix item walks the single read port
// of the sample memory one voice per cycle, each sample passes a short
// scale pipeline (volume multiply, scale by 256/127 through a reciprocal of
// 127), and the two accumulators are saturated to 16 bits. Action code 3 is
// taken and dropped. Sample memory has no reset; reading a byte that was
// never loaded gives an undefined sample. Handles count from 100 to 65535
// and then restart at 100.
module eight_voice_sample_mixer_core import esm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  head_t head;
  logic  pop;

  // Accept, classify and queue commands.
  esm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .head      (head),
    .pop       (pop)
  );

  // Execute commands against voice state and sample memory.
  esm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

  // Never take a command from an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty command queue");

  // A start result carries silent samples.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.kind == KIND_START)) |->
      (res.left_sample == 16'sd0) && (res.right_sample == 16'sd0))
    else $error("start result with nonzero samples");

  // Handles never fall below the first handle value.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.kind == KIND_START)) |-> (res.handle >= HANDLE_FIRST))
    else $error("handle below first value");

  // No result right after reset.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule
